FILE: rtl/core/touch_slot_tracker_defines.svh
// Assertion macros for the touch slot tracker.
// Included by RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef TOUCH_SLOT_TRACKER_DEFINES_SVH
`define TOUCH_SLOT_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define TST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("touch_slot_tracker check failed");
`define TST_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("touch_slot_tracker reset check failed");
`else
`define TST_ASSERT(lbl, prop)
`define TST_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: rtl/core/tst_pkg.sv
// Shared types, constants and helpers for the touch slot tracker.
// No dependencies; imported by tst_ctrl, tst_dp and touch_slot_tracker.
`timescale 1ns / 1ps

package tst_pkg;

  localparam int SLOTS = 5;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int CFG_W      = 11;
  localparam int OUT_MAX    = 1024;
  localparam int RST_WIDTH  = 960;
  localparam int RST_HEIGHT = 480;

  // raw * size, then divide by 1920 = 128 * 15 and 1088 = 64 * 17
  localparam int PROD_W  = 23;
  localparam int Q_W     = 12;
  localparam int RCP_SH  = 16;
  localparam int X_SHIFT = 7;
  localparam int X_DIV   = 15;
  localparam int X_RECIP = 65535 / X_DIV;
  localparam int Y_SHIFT = 6;
  localparam int Y_DIV   = 17;
  localparam int Y_RECIP = 65535 / Y_DIV;

  typedef enum logic [1:0] {
    ACT_UP   = 2'd0,
    ACT_DOWN = 2'd1,
    ACT_MOVE = 2'd2
  } tst_act_e;

  typedef enum logic [0:0] {
    CFG_OUT_WIDTH  = 1'b0,
    CFG_OUT_HEIGHT = 1'b1
  } tst_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RECIP,
    ST_UPDATE,
    ST_SWEEP
  } tst_state_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  finger_id;
    logic [11:0] raw_x;
    logic [11:0] raw_y;
  } tst_in_t;

  typedef struct packed {
    tst_act_e    action;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [2:0]  slot_index;
    logic        last;
  } tst_res_t;

  typedef struct packed {
    logic load;
    logic mult;
    logic recip;
    logic update;
    logic sweep;
  } tst_cmd_t;

  typedef struct packed {
    logic is_frame;
    logic full;
    logic sweep_end;
  } tst_stat_t;

  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > CFG_W'(OUT_MAX)) begin
      r = CFG_W'(OUT_MAX);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/tst_ctrl.sv
// Sequencer of the touch slot tracker: accepts items and steps the datapath.
// Depends on tst_pkg (state, command and status types).
`timescale 1ns / 1ps

module tst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  tst_pkg::tst_stat_t stat_i,
  output tst_pkg::tst_cmd_t  cmd_o
);
  import tst_pkg::*;

  tst_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (stat_i.is_frame) state_d = ST_SWEEP;
        else if (stat_i.full) state_d = ST_IDLE;
        else state_d = ST_RECIP;
      end
      ST_RECIP:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      ST_SWEEP: begin
        if (stat_i.sweep_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_MUL:    cmd_o.mult   = 1'b1;
      ST_RECIP:  cmd_o.recip  = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_SWEEP:  cmd_o.sweep  = 1'b1;
      default:   busy_o       = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/tst_dp.sv
// Datapath of the touch slot tracker: config registers, coordinate scaling,
// slot table and result register. Depends on tst_pkg and the defines header.
`timescale 1ns / 1ps
`include "touch_slot_tracker_defines.svh"

module tst_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tst_pkg::tst_in_t        in_i,
  input  tst_pkg::tst_cmd_t       cmd_i,
  output tst_pkg::tst_stat_t      stat_o,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_idx_i,
  input  logic [tst_pkg::CFG_W-1:0] cfg_data_i,
  output logic                    res_valid_o,
  output tst_pkg::tst_res_t       res_o
);
  import tst_pkg::*;

  localparam int VX_W = PROD_W - X_SHIFT;
  localparam int VY_W = PROD_W - Y_SHIFT;

  logic [CFG_W-1:0] width_q, width_d, height_q, height_d;
  tst_in_t          item_q;
  logic [PROD_W-1:0] prod_x_q, prod_y_q;
  logic [Q_W-1:0]   qx_q, qy_q;

  logic [SLOTS-1:0] busy_q, busy_d, seen_q, seen_d;
  logic [7:0]       finger_q [SLOTS];
  logic [7:0]       finger_d [SLOTS];
  logic [9:0]       lastx_q  [SLOTS];
  logic [9:0]       lastx_d  [SLOTS];
  logic [9:0]       lasty_q  [SLOTS];
  logic [9:0]       lasty_d  [SLOTS];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] sw_idx_q, sw_idx_d;
  logic             res_valid_q, res_valid_d;
  tst_res_t         res_q, res_d;

  logic [CFG_W-1:0] sx, sy;
  logic [VX_W-1:0]  vx;
  logic [VY_W-1:0]  vy;
  logic [31:0]      mx, my;
  logic [VX_W-1:0]  remx;
  logic [VY_W-1:0]  remy;
  logic [Q_W-1:0]   qx_c, qy_c;
  logic [9:0]       pos_x, pos_y;

  logic [SLOTS-1:0] hit, rel, above;
  logic             hit_any, free_any, moved;
  logic [IDX_W-1:0] hit_idx, free_idx, sel_idx, rd_idx;
  logic [IDX_W+2:0] idx_ext;
  logic [9:0]       rd_x, rd_y;

  assign sx = eff_size(width_q);
  assign sy = eff_size(height_q);

  // divide by constant: reciprocal multiply, then one correction step
  assign vx = prod_x_q[PROD_W-1:X_SHIFT];
  assign vy = prod_y_q[PROD_W-1:Y_SHIFT];
  assign mx = 32'(vx) * 32'(X_RECIP);
  assign my = 32'(vy) * 32'(Y_RECIP);
  assign remx = vx - VX_W'(qx_q) * VX_W'(X_DIV);
  assign remy = vy - VY_W'(qy_q) * VY_W'(Y_DIV);
  assign qx_c = qx_q + Q_W'(remx >= VX_W'(X_DIV));
  assign qy_c = qy_q + Q_W'(remy >= VY_W'(Y_DIV));
  assign pos_x = (qx_c >= Q_W'(sx)) ? 10'(sx - CFG_W'(1)) : qx_c[9:0];
  assign pos_y = (qy_c >= Q_W'(sy)) ? 10'(sy - CFG_W'(1)) : qy_c[9:0];

  always_comb begin
    hit      = '0;
    hit_idx  = '0;
    free_idx = '0;
    above    = '0;
    for (int s = 0; s < SLOTS; s++) begin
      hit[s]   = busy_q[s] && (finger_q[s] == item_q.finger_id);
      above[s] = (IDX_W + 1)'(s) > {1'b0, sw_idx_q};
    end
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (hit[s]) hit_idx = IDX_W'(s);
      if (!busy_q[s]) free_idx = IDX_W'(s);
    end
  end

  assign hit_any  = |hit;
  assign free_any = ~&busy_q;
  assign sel_idx  = hit_any ? hit_idx : free_idx;
  assign rd_idx   = cmd_i.sweep ? sw_idx_q : sel_idx;
  assign rd_x     = lastx_q[rd_idx];
  assign rd_y     = lasty_q[rd_idx];
  assign moved    = (rd_x != pos_x) || (rd_y != pos_y);
  assign rel      = busy_q & ~seen_q;
  assign idx_ext  = {3'b000, rd_idx};

  assign stat_o.is_frame  = item_q.cmd;
  assign stat_o.full      = cnt_q >= CNT_W'(SLOTS);
  assign stat_o.sweep_end = sw_idx_q == IDX_W'(SLOTS - 1);

  always_comb begin
    width_d     = width_q;
    height_d    = height_q;
    busy_d      = busy_q;
    seen_d      = seen_q;
    finger_d    = finger_q;
    lastx_d     = lastx_q;
    lasty_d     = lasty_q;
    cnt_d       = cnt_q;
    sw_idx_d    = sw_idx_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OUT_WIDTH:  width_d  = cfg_data_i;
        CFG_OUT_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end

    if (cmd_i.load) sw_idx_d = '0;

    if (cmd_i.update) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (hit_any || free_any) begin
        seen_d[sel_idx]  = 1'b1;
        lastx_d[sel_idx] = pos_x;
        lasty_d[sel_idx] = pos_y;
        res_d.pos_x      = pos_x;
        res_d.pos_y      = pos_y;
        res_d.slot_index = idx_ext[2:0];
        res_d.last       = 1'b1;
        if (!hit_any) begin
          busy_d[sel_idx]   = 1'b1;
          finger_d[sel_idx] = item_q.finger_id;
          res_d.action      = ACT_DOWN;
          res_valid_d       = 1'b1;
        end else begin
          res_d.action = ACT_MOVE;
          res_valid_d  = moved;
        end
      end
    end

    if (cmd_i.sweep) begin
      if (rel[sw_idx_q]) begin
        busy_d[sw_idx_q] = 1'b0;
        res_d.action     = ACT_UP;
        res_d.pos_x      = rd_x;
        res_d.pos_y      = rd_y;
        res_d.slot_index = idx_ext[2:0];
        res_d.last       = (rel & above) == '0;
        res_valid_d      = 1'b1;
      end
      sw_idx_d = sw_idx_q + IDX_W'(1);
      if (stat_o.sweep_end) begin
        seen_d   = '0;
        cnt_d    = '0;
        sw_idx_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= CFG_W'(RST_WIDTH);
      height_q    <= CFG_W'(RST_HEIGHT);
      busy_q      <= '0;
      seen_q      <= '0;
      cnt_q       <= '0;
      sw_idx_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      busy_q      <= busy_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      sw_idx_q    <= sw_idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_i;
    if (cmd_i.mult) begin
      prod_x_q <= PROD_W'(item_q.raw_x) * PROD_W'(sx);
      prod_y_q <= PROD_W'(item_q.raw_y) * PROD_W'(sy);
    end
    if (cmd_i.recip) begin
      qx_q <= mx[RCP_SH+Q_W-1:RCP_SH];
      qy_q <= my[RCP_SH+Q_W-1:RCP_SH];
    end
    finger_q <= finger_d;
    lastx_q  <= lastx_d;
    lasty_q  <= lasty_d;
    res_q    <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `TST_ASSERT(a_seen_busy, (seen_q & ~busy_q) == '0)
  `TST_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(SLOTS))
  `TST_ASSERT(a_sweep_clear, cmd_i.sweep && stat_o.sweep_end |=> seen_q == '0 && cnt_q == '0)
  `TST_ASSERT_RST(a_rst_quiet, !rst_ni |-> !res_valid_o && busy_q == '0)

endmodule

FILE: rtl/core/touch_slot_tracker.sv
// Touch slot tracker: raw multi-touch reports in, pointer down/move/up events out.
// Top level; instantiates tst_ctrl and tst_dp, depends on tst_pkg.
//
// Usage:
//   Input: drive in_i and raise start_i; the item transfers at a rising edge
//   with start_i high and busy_o low. in_i.cmd = 0 is a touch report,
//   in_i.cmd = 1 ends the frame.
//   Output: each event shows on res_o for one cycle with res_valid_o high;
//   res_o.last flags the final event of an item. There is no backpressure.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 = out_width,
//   1 = out_height) at the clock edge; write only while busy_o is low.
// Sequence after a transfer, until the next transfer can be taken:
//   touch report: multiply, reciprocal multiply, table update; its event,
//   if any, strobes in the cycle after the update, as the block is idle again.
//   report past the per-frame limit: multiply only, no event.
//   end of frame: multiply, then a sweep that visits one slot per cycle;
//   each up event strobes in the cycle after its slot is visited.
// Reset: all slots free, frame marks and report count cleared, out_width 960
// and out_height 480.
`timescale 1ns / 1ps

module touch_slot_tracker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  tst_pkg::tst_in_t          in_i,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [tst_pkg::CFG_W-1:0] cfg_data_i,
  output logic                      res_valid_o,
  output tst_pkg::tst_res_t         res_o
);
  import tst_pkg::*;

  tst_cmd_t  cmd;
  tst_stat_t stat;

  tst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tst_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule
